// ===== rtl/core/ktr_pkg.sv =====
// ----------------------------------------------------------------------------
// ktr_pkg
// Shared widths, limits, register map and types of the keypoint threshold
// regulator.
// ----------------------------------------------------------------------------
package ktr_pkg;

   localparam int COUNT_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int THR_BITS   = 30;
   localparam int RATE_BITS  = 24;
   localparam int ITER_BITS  = 8;

   // quotient of (rate << FRAC_BITS) / |diff| and product alpha * |delta|
   localparam int QUOT_BITS  = RATE_BITS + FRAC_BITS;
   localparam int PROD_BITS  = THR_BITS + COUNT_BITS;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int STEP_BITS  = $clog2(QUOT_BITS + 1);

   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;

   localparam logic [THR_BITS-1:0] THR_MAX = THR_BITS'(15000 << FRAC_BITS);
   localparam logic [THR_BITS-1:0] THR_MIN = THR_BITS'(1 << FRAC_BITS);

   localparam logic [COUNT_BITS-1:0] COUNT_LOW_RST  = COUNT_BITS'(400);
   localparam logic [COUNT_BITS-1:0] COUNT_HIGH_RST = COUNT_BITS'(500);
   localparam logic [ITER_BITS-1:0]  ITER_LIMIT_RST = ITER_BITS'(50);
   localparam logic [RATE_BITS-1:0]  BASE_RATE_RST  = RATE_BITS'(65536);
   localparam logic [THR_BITS-1:0]   START_THR_RST  = THR_BITS'(32768000);

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_COUNT_LOW  = 3'd0;
   localparam logic [2:0] REG_COUNT_HIGH = 3'd1;
   localparam logic [2:0] REG_ITER_LIMIT = 3'd2;
   localparam logic [2:0] REG_BASE_RATE  = 3'd3;
   localparam logic [2:0] REG_START_THR  = 3'd4;

   typedef struct packed {
      logic [COUNT_BITS-1:0] point_count;
      logic                  run_start;
      logic                  reload_start;
   } req_payload_type;

   typedef struct packed {
      logic [THR_BITS-1:0] next_threshold;
      logic                hit;
      logic                run_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count_low;
      logic [COUNT_BITS-1:0] count_high;
      logic [ITER_BITS-1:0]  iteration_limit;
      logic [RATE_BITS-1:0]  base_rate;
      logic [THR_BITS-1:0]   start_threshold;
   } cfg_type;

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } mdu_op_type;

   typedef struct packed {
      logic                 start;
      mdu_op_type           op;
      logic [QUOT_BITS-1:0] opa;   // dividend, or multiplier in the low bits
      logic [THR_BITS-1:0]  opb;   // divisor, or multiplicand
   } mdu_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic [QUOT_BITS-1:0] quotient;
      logic [PROD_BITS-1:0] product;
   } mdu_rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_MUL,
      S_ADD,
      S_OUT
   } state_type;

endpackage

// ===== rtl/core/ktr_csr.sv =====
// ----------------------------------------------------------------------------
// ktr_csr
// APB-style register file holding the window, iteration limit, base rate
// and start threshold.
// ----------------------------------------------------------------------------
module ktr_csr import ktr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[ADDR_BITS-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_COUNT_LOW:  cfg_in.count_low       = pwdata[COUNT_BITS-1:0];
            REG_COUNT_HIGH: cfg_in.count_high      = pwdata[COUNT_BITS-1:0];
            REG_ITER_LIMIT: cfg_in.iteration_limit = pwdata[ITER_BITS-1:0];
            REG_BASE_RATE:  cfg_in.base_rate       = pwdata[RATE_BITS-1:0];
            REG_START_THR:  cfg_in.start_threshold = pwdata[THR_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_COUNT_LOW:  prdata = DATA_BITS'(cfg_ff.count_low);
         REG_COUNT_HIGH: prdata = DATA_BITS'(cfg_ff.count_high);
         REG_ITER_LIMIT: prdata = DATA_BITS'(cfg_ff.iteration_limit);
         REG_BASE_RATE:  prdata = DATA_BITS'(cfg_ff.base_rate);
         REG_START_THR:  prdata = DATA_BITS'(cfg_ff.start_threshold);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_low       <= COUNT_LOW_RST;
         cfg_ff.count_high      <= COUNT_HIGH_RST;
         cfg_ff.iteration_limit <= ITER_LIMIT_RST;
         cfg_ff.base_rate       <= BASE_RATE_RST;
         cfg_ff.start_threshold <= START_THR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/ktr_mdu.sv =====
// ----------------------------------------------------------------------------
// ktr_mdu
// Shared multiply/divide unit: one narrow adder, used as a restoring
// divider (one quotient bit per cycle) or a shift-add multiplier (one
// multiplier bit per cycle).
// ----------------------------------------------------------------------------
module ktr_mdu import ktr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mdu_cmd_type cmd,
   output mdu_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   mdu_op_type           op_ff, op_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [THR_BITS-1:0]  acc_ff, acc_in;
   logic [QUOT_BITS-1:0] sh_ff, sh_in;
   logic [THR_BITS-1:0]  opnd_ff, opnd_in;

   logic [THR_BITS:0]    add_a;
   logic [THR_BITS:0]    add_b;
   logic                 add_sub;
   logic [THR_BITS+1:0]  add_sum;
   logic                 qbit;

   // shared adder
   always_comb begin
      if (op_ff == OP_DIV) begin
         add_a   = {acc_ff, sh_ff[QUOT_BITS-1]};
         add_b   = {1'b0, opnd_ff};
         add_sub = 1'b1;
      end else begin
         add_a   = {1'b0, acc_ff};
         add_b   = sh_ff[0] ? {1'b0, opnd_ff} : '0;
         add_sub = 1'b0;
      end
      add_sum = {1'b0, add_a}
              + ({1'b0, add_b} ^ {(THR_BITS + 2){add_sub}})
              + (THR_BITS + 2)'(add_sub);
      qbit    = ~add_sum[THR_BITS+1];
   end

   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opnd_in = opnd_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = (cmd.op == OP_DIV) ? STEP_BITS'(QUOT_BITS) : STEP_BITS'(COUNT_BITS);
         acc_in  = '0;
         sh_in   = cmd.opa;
         opnd_in = cmd.opb;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - STEP_BITS'(1);
         busy_in = (cnt_ff != STEP_BITS'(1));
         if (op_ff == OP_DIV) begin
            // keep the trial difference only when it did not borrow
            acc_in = qbit ? add_sum[THR_BITS-1:0] : add_a[THR_BITS-1:0];
            sh_in  = {sh_ff[QUOT_BITS-2:0], qbit};
         end else begin
            acc_in = add_sum[THR_BITS:1];
            sh_in  = {sh_ff[QUOT_BITS-1:COUNT_BITS], add_sum[0],
                      sh_ff[COUNT_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= OP_DIV;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      sh_ff   <= sh_in;
      opnd_ff <= opnd_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.quotient = sh_ff;
   assign rsp.product  = {acc_ff, sh_ff[COUNT_BITS-1:0]};

endmodule

// ===== rtl/core/keypoint_threshold_regulator_unit.sv =====
// ----------------------------------------------------------------------------
// keypoint_threshold_regulator_unit
// Steers a detector threshold toward a keypoint count window: hit, midpoint
// step or gradient step alpha*(count-mid) with clamping to 1.0..15000.0.
// ----------------------------------------------------------------------------
// Sequence: a hit or midpoint step goes S_IDLE, S_EVAL, S_OUT; a gradient step
//   adds S_MUL and S_ADD after S_EVAL, and S_DIV before S_MUL when it divides.
// The shared unit runs a 40-step divide and a 16-step multiply;
//   one item is in work at a time, so no new input is taken until the item
//   has passed S_OUT; the result waits in an output register.
// Reset (synchronous) restores register defaults, threshold 500.0 and rate 1.0.
// ----------------------------------------------------------------------------
module keypoint_threshold_regulator_unit import ktr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type     cfg;
   mdu_cmd_type mdu_cmd;
   mdu_rsp_type mdu_rsp;

   state_type   state_ff, state_in;

   logic [COUNT_BITS-1:0] point_ff, point_in;
   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic [THR_BITS-1:0]   prior_thr_ff, prior_thr_in;
   logic [COUNT_BITS-1:0] prior_cnt_ff, prior_cnt_in;
   logic [RATE_BITS-1:0]  rate_ff, rate_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;
   logic [THR_BITS-1:0]   new_thr_ff, new_thr_in;
   logic [RATE_BITS-1:0]  new_rate_ff, new_rate_in;
   logic                  hit_ff, hit_in;
   logic                  neg_ff, neg_in;
   logic [COUNT_BITS-1:0] mag_ff, mag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  out_free;
   logic                  commit;
   logic [THR_BITS-1:0]   start_clamped;
   logic                  in_window;
   logic                  later;
   logic                  use_mid;
   logic                  use_div;
   logic [COUNT_BITS:0]   mid_sum;
   logic [COUNT_BITS-1:0] mid;
   logic [COUNT_BITS:0]   delta;
   logic [COUNT_BITS-1:0] mag_now;
   logic [THR_BITS:0]     diff;
   logic [THR_BITS-1:0]   abs_diff;
   logic [THR_BITS:0]     avg_sum;
   logic [THR_BITS-1:0]   alpha_sat;
   logic [SUM_BITS-1:0]   ext_thr;
   logic [SUM_BITS-1:0]   ext_prod;
   logic [SUM_BITS-1:0]   step_sum;
   logic [THR_BITS-1:0]   step_clamped;
   logic [ITER_BITS-1:0]  iter_next;
   logic [ITER_BITS-1:0]  limit_eff;
   logic                  run_done;

   ktr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ktr_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .cmd   (mdu_cmd),
      .rsp   (mdu_rsp)
   );

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // decision terms, valid in S_EVAL
   always_comb begin
      start_clamped = cfg.start_threshold;
      if (cfg.start_threshold < THR_MIN) begin
         start_clamped = THR_MIN;
      end else if (cfg.start_threshold > THR_MAX) begin
         start_clamped = THR_MAX;
      end

      in_window = (point_ff >= cfg.count_low) && (point_ff <= cfg.count_high);
      later     = (iter_ff != '0);
      use_mid   = later &&
                  (((point_ff < cfg.count_low) && (prior_cnt_ff > cfg.count_high)) ||
                   ((point_ff > cfg.count_high) && (prior_cnt_ff < cfg.count_low)));

      mid_sum   = {1'b0, cfg.count_low} + {1'b0, cfg.count_high};
      mid       = mid_sum[COUNT_BITS:1];
      delta     = {1'b0, point_ff} - {1'b0, mid};
      mag_now   = delta[COUNT_BITS] ? (~delta[COUNT_BITS-1:0] + COUNT_BITS'(1))
                                    : delta[COUNT_BITS-1:0];

      diff      = {1'b0, thr_ff} - {1'b0, prior_thr_ff};
      abs_diff  = diff[THR_BITS] ? (~diff[THR_BITS-1:0] + THR_BITS'(1))
                                 : diff[THR_BITS-1:0];
      use_div   = later && (diff != '0);

      avg_sum   = {1'b0, thr_ff} + {1'b0, prior_thr_ff};

      alpha_sat = (mdu_rsp.quotient > QUOT_BITS'(THR_MAX)) ? THR_MAX
                                                          : mdu_rsp.quotient[THR_BITS-1:0];

      ext_thr   = SUM_BITS'(thr_ff);
      ext_prod  = SUM_BITS'(mdu_rsp.product);
      step_sum  = neg_ff ? (ext_thr - ext_prod) : (ext_thr + ext_prod);
      if ($signed(step_sum) < $signed(SUM_BITS'(THR_MIN))) begin
         step_clamped = THR_MIN;
      end else if ($signed(step_sum) > $signed(SUM_BITS'(THR_MAX))) begin
         step_clamped = THR_MAX;
      end else begin
         step_clamped = step_sum[THR_BITS-1:0];
      end

      iter_next = iter_ff + ITER_BITS'(1);
      limit_eff = (cfg.iteration_limit == '0) ? ITER_BITS'(1) : cfg.iteration_limit;
      run_done  = hit_ff || (iter_next == '0) || (iter_next >= limit_eff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (in_window || use_mid) begin
               state_in = S_OUT;
            end else if (use_div) begin
               state_in = S_DIV;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DIV: begin
            if (!mdu_rsp.busy) state_in = S_MUL;
         end
         S_MUL: begin
            if (!mdu_rsp.busy) state_in = S_ADD;
         end
         S_ADD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready   = 1'b0;
      commit      = 1'b0;
      mdu_cmd     = '0;
      mdu_cmd.op  = OP_DIV;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_EVAL: begin
            if (!in_window && !use_mid) begin
               mdu_cmd.start = 1'b1;
               if (use_div) begin
                  mdu_cmd.op  = OP_DIV;
                  mdu_cmd.opa = {rate_ff, FRAC_BITS'(0)};
                  mdu_cmd.opb = abs_diff;
               end else begin
                  mdu_cmd.op  = OP_MUL;
                  mdu_cmd.opa = QUOT_BITS'(mag_now);
                  mdu_cmd.opb = THR_BITS'(rate_ff);
               end
            end
         end
         S_DIV: begin
            if (!mdu_rsp.busy) begin
               mdu_cmd.start = 1'b1;
               mdu_cmd.op    = OP_MUL;
               mdu_cmd.opa   = QUOT_BITS'(mag_ff);
               mdu_cmd.opb   = alpha_sat;
            end
         end
         S_OUT: begin
            commit = out_free;
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      point_in     = point_ff;
      thr_in       = thr_ff;
      prior_thr_in = prior_thr_ff;
      prior_cnt_in = prior_cnt_ff;
      rate_in      = rate_ff;
      iter_in      = iter_ff;
      new_thr_in   = new_thr_ff;
      new_rate_in  = new_rate_ff;
      hit_in       = hit_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (req_fire) begin
         point_in = req_payload.point_count;
         if (req_payload.run_start) begin
            iter_in = '0;
            rate_in = cfg.base_rate;
            if (req_payload.reload_start) thr_in = start_clamped;
         end
      end

      if (state_ff == S_EVAL) begin
         hit_in      = in_window;
         neg_in      = delta[COUNT_BITS];
         mag_in      = mag_now;
         new_rate_in = use_mid ? (rate_ff >> 1) : rate_ff;
         new_thr_in  = use_mid ? avg_sum[THR_BITS:1] : thr_ff;
      end

      if (state_ff == S_ADD) begin
         new_thr_in = step_clamped;
      end

      if (commit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.next_threshold = hit_ff ? thr_ff : new_thr_ff;
         rsp_data_in.hit            = hit_ff;
         rsp_data_in.run_done       = run_done;
         if (!hit_ff) begin
            prior_thr_in = thr_ff;
            thr_in       = new_thr_ff;
            prior_cnt_in = point_ff;
            iter_in      = iter_next;
            rate_in      = new_rate_ff;
         end
         // a finished run starts over on the next item
         if (run_done) begin
            iter_in = '0;
            rate_in = cfg.base_rate;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= START_THR_RST;
         prior_thr_ff <= '0;
         prior_cnt_ff <= '0;
         rate_ff      <= BASE_RATE_RST;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         prior_thr_ff <= prior_thr_in;
         prior_cnt_ff <= prior_cnt_in;
         rate_ff      <= rate_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff    <= point_in;
      new_thr_ff  <= new_thr_in;
      new_rate_ff <= new_rate_in;
      hit_ff      <= hit_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
